[hdl/lmnf_pkg.sv]
// Shared constants, types and font lookup for the LED matrix frame generator.
`timescale 1ns / 1ps
`default_nettype none
package lmnf_pkg;

  localparam int NUM_MODULES_DEF = 4;
  localparam int FRAME_W         = 64;
  localparam int DIGIT_W         = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SEND_INIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT = 2'd2;

  // Driver command addresses
  localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
  localparam logic [7:0] ADDR_SCAN_LIM  = 8'h0B;
  localparam logic [7:0] ADDR_DISP_TEST = 8'h0F;
  localparam logic [7:0] DATA_NORMAL_OP = 8'h01;
  localparam logic [7:0] DATA_TEST_OFF  = 8'h00;

  // Frame sequence: four init frames then eight row frames
  localparam int         SEQ_W       = 4;
  localparam logic [3:0] SEQ_SHUTDOWN  = 4'd0;
  localparam logic [3:0] SEQ_INTENSITY = 4'd1;
  localparam logic [3:0] SEQ_SCAN_LIM  = 4'd2;
  localparam logic [3:0] SEQ_DISP_TEST = 4'd3;
  localparam logic [3:0] SEQ_FIRST_ROW = 4'd4;
  localparam logic [3:0] SEQ_LAST_ROW  = 4'd11;
  localparam logic [7:0] ROW_ADDR_LAST = 8'd8;

  typedef struct packed {
    logic       send_init;
    logic [3:0] intensity;
    logic [2:0] scan_limit;
  } cfg_t;

  // Glyph row byte for a decimal digit
  function automatic logic [7:0] glyph_row(input logic [DIGIT_W-1:0] digit,
                                           input logic [2:0] row);
    logic [63:0] g;
    case (digit)
      4'd0:    g = 64'h3c6666666666663c;
      4'd1:    g = 64'h183818181818183c;
      4'd2:    g = 64'h3c66060c1830607e;
      4'd3:    g = 64'h3c66061c0606663c;
      4'd4:    g = 64'h060e1626667f0606;
      4'd5:    g = 64'h7e60607c0606663c;
      4'd6:    g = 64'h3c62607c6666663c;
      4'd7:    g = 64'h7e060c1830303030;
      4'd8:    g = 64'h3c66663c6666663c;
      4'd9:    g = 64'h3c6666663e06663c;
      default: g = 64'h0;
    endcase
    // row 0 sits in the top byte
    return g[(7 - row) * 8 +: 8];
  endfunction

endpackage
`default_nettype wire

[hdl/lmnf_front.sv]
// Front end: accepts a number and splits it into one decimal digit per module.
`timescale 1ns / 1ps
`default_nettype none
module lmnf_front #(
  parameter int NUM_MODULES = lmnf_pkg::NUM_MODULES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [15:0]                            in_shown_value,
  output logic                                        push_valid,
  input  wire logic                                   push_ready,
  output logic [NUM_MODULES*lmnf_pkg::DIGIT_W-1:0]    push_digits
);
  import lmnf_pkg::*;

  localparam int SW = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam logic [SW-1:0] SLOT_TOP = SW'(NUM_MODULES - 1);
  localparam logic [16:0]   RECIP10  = 17'h0CCCD;

  typedef enum logic [1:0] {FR_IDLE, FR_CONV, FR_HOLD} fr_state_t;

  fr_state_t                       state_r;
  logic [15:0]                     val_r;
  logic [SW-1:0]                   slot_r;
  logic [NUM_MODULES*DIGIT_W-1:0]  digs_r;
  logic [32:0]                     prod;
  logic [15:0]                     quot;
  logic [15:0]                     rem;

  // divide by ten through the reciprocal, exact over 16 bits
  assign prod = 33'(val_r) * 33'(RECIP10);
  assign quot = 16'(prod[32:19]);
  assign rem  = val_r - ((quot << 3) + (quot << 1));

  assign in_ready    = (state_r == FR_IDLE);
  assign push_valid  = (state_r == FR_HOLD);
  assign push_digits = digs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      case (state_r)
        FR_IDLE: begin
          if (in_valid) begin
            val_r   <= in_shown_value;
            slot_r  <= SLOT_TOP;
            state_r <= FR_CONV;
          end
        end
        FR_CONV: begin
          // least significant digit lands in the highest slot
          digs_r[slot_r*DIGIT_W +: DIGIT_W] <= rem[DIGIT_W-1:0];
          val_r <= quot;
          if (slot_r == '0) begin
            state_r <= FR_HOLD;
          end else begin
            slot_r <= slot_r - 1'b1;
          end
        end
        FR_HOLD: begin
          if (push_ready) begin
            state_r <= FR_IDLE;
          end
        end
        default: state_r <= FR_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/lmnf_fifo.sv]
// Two-entry register queue between the digit front end and the frame sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lmnf_fifo #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/lmnf_back.sv]
// Back end: feeds init and row frames into the output register, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module lmnf_back #(
  parameter int NUM_MODULES = lmnf_pkg::NUM_MODULES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire lmnf_pkg::cfg_t                       cfg,
  input  wire logic                                 pop_valid,
  output logic                                      pop_ready,
  input  wire logic [NUM_MODULES*lmnf_pkg::DIGIT_W-1:0] pop_digits,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [lmnf_pkg::FRAME_W-1:0]              out_frame,
  output logic                                      out_last
);
  import lmnf_pkg::*;

  logic                            busy_r;
  logic [SEQ_W-1:0]                seq_r;
  logic [NUM_MODULES*DIGIT_W-1:0]  digs_r;
  logic                            out_valid_r;
  logic [FRAME_W-1:0]              frame_r;
  logic                            last_r;
  logic                            emit;
  logic                            seq_end;
  logic                            pop;
  logic [FRAME_W-1:0]              frame_nxt;
  logic [7:0]                      addr;
  logic [7:0]                      data_same;
  logic                            is_row;
  logic [2:0]                      row;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign seq_end   = (seq_r == SEQ_LAST_ROW);
  assign pop_ready = !busy_r || (emit && seq_end);
  assign pop       = pop_valid && pop_ready;
  assign is_row    = (seq_r >= SEQ_FIRST_ROW);
  assign row       = 3'(seq_r - SEQ_FIRST_ROW);

  always_comb begin
    case (seq_r)
      SEQ_SHUTDOWN: begin
        addr = ADDR_SHUTDOWN;  data_same = DATA_NORMAL_OP;
      end
      SEQ_INTENSITY: begin
        addr = ADDR_INTENSITY; data_same = {4'd0, cfg.intensity};
      end
      SEQ_SCAN_LIM: begin
        addr = ADDR_SCAN_LIM;  data_same = {5'd0, cfg.scan_limit};
      end
      SEQ_DISP_TEST: begin
        addr = ADDR_DISP_TEST; data_same = DATA_TEST_OFF;
      end
      default: begin
        addr = 8'({1'b0, row} + 4'd1); data_same = 8'd0;
      end
    endcase
  end

  always_comb begin
    frame_nxt = '0;
    for (int s = 0; s < NUM_MODULES; s++) begin
      frame_nxt[(NUM_MODULES - 1 - s)*16 +: 16] =
        {addr, is_row ? glyph_row(digs_r[s*DIGIT_W +: DIGIT_W], row) : data_same};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
        seq_r  <= cfg.send_init ? SEQ_SHUTDOWN : SEQ_FIRST_ROW;
        digs_r <= pop_digits;
      end else if (emit) begin
        if (seq_end) begin
          busy_r <= 1'b0;
        end else begin
          seq_r <= seq_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_r <= frame_nxt;
      last_r  <= seq_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame = frame_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

[hdl/led_matrix_number_frames_top.sv]
// Top level of the cascaded LED matrix number frame generator.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | direction | ports                               | handshake
//  --------+-----------+-------------------------------------+-------------------
//  in      | input     | in_shown_value                      | in_valid/in_ready
//  out     | output    | out_frame, out_last                 | out_valid/out_ready
//  cfg     | input     | cfg_index, cfg_data                 | cfg_valid/cfg_ready
//
//  Each number yields 12 frames with send_init set and 8 without, one frame per
//  cycle from the back-end sequencer while the output is not stalled.
//  Digit extraction in the front end overlaps the frames of the previous number
//  through a two-item queue. Reset (synchronous, rst_n low) empties the queue
//  and restores send_init = 1, intensity = 1, scan_limit = 7. A stalled output
//  holds its frame in the output register while the sequencer waits; the front
//  keeps accepting until the queue fills. cfg_ready is always high.
//
module led_matrix_number_frames_top #(
  parameter int NUM_MODULES = lmnf_pkg::NUM_MODULES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [15:0]                       in_shown_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [lmnf_pkg::FRAME_W-1:0]           out_frame,
  output logic                                   out_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lmnf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lmnf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lmnf_pkg::*;

  localparam int DW = NUM_MODULES * DIGIT_W;

  cfg_t          cfg_r;
  logic          push_valid;
  logic          push_ready;
  logic [DW-1:0] push_digits;
  logic          pop_valid;
  logic          pop_ready;
  logic [DW-1:0] pop_digits;

  // Configuration registers; writes to an unknown index drop silently
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.send_init  <= 1'b1;
      cfg_r.intensity  <= 4'd1;
      cfg_r.scan_limit <= 3'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEND_INIT:  cfg_r.send_init  <= cfg_data[0];
        REG_INTENSITY:  cfg_r.intensity  <= cfg_data[3:0];
        REG_SCAN_LIMIT: cfg_r.scan_limit <= cfg_data[2:0];
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  // Front: take the number, split it into digits
  lmnf_front #(.NUM_MODULES(NUM_MODULES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_shown_value (in_shown_value),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_digits    (push_digits)
  );

  // Queue: decouple digit extraction from frame output
  lmnf_fifo #(.W(DW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_digits),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_digits)
  );

  // Back: sequence init and row frames
  lmnf_back #(.NUM_MODULES(NUM_MODULES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_digits (pop_digits),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_frame  (out_frame),
    .out_last   (out_last)
  );

  // The last flag marks exactly the frames that carry row address eight
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_frame[15:8] == ROW_ADDR_LAST)))
    else $error("last flag does not match row address");

  // The front end goes busy right after it takes an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front accepted two items back to back");

  // Nothing pushed into a full queue is lost
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> push_valid)
    else $error("front dropped digits while queue was full");

endmodule
`default_nettype wire
